### rtl/sstf_disk_seek_cost_macros.svh
// Assertion helpers; clock and reset are the block's own i_clk / i_rst_n.
`ifndef SSTF_DISK_SEEK_COST_MACROS_SVH
`define SSTF_DISK_SEEK_COST_MACROS_SVH

`define SSTF_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define SSTF_ASSERT(lbl, prop) `SSTF_ASSERT_MSG(lbl, prop, "sstf check failed")

`endif

### rtl/sstf_pkg.sv
`default_nettype none

package sstf_pkg;

    localparam int SECTOR_W         = 16;
    localparam int HEAD_START_RESET = 2500;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### rtl/sstf_gap_cmp.sv
`default_nettype none

// Seek distance from the head to one stored entry, and whether it beats the best so far.
module sstf_gap_cmp import sstf_pkg::*; #(
    parameter int TRACK_BITS = 13
) (
    input  wire logic                  i_valid,
    input  wire logic                  i_served,
    input  wire logic [TRACK_BITS-1:0] i_track,
    input  wire logic [TRACK_BITS-1:0] i_head,
    input  wire logic [TRACK_BITS:0]   i_best,
    output logic      [TRACK_BITS-1:0] o_gap,
    output logic                       o_take
);

    always_comb begin
        if (i_track >= i_head) begin
            o_gap = i_track - i_head;
        end else begin
            o_gap = i_head - i_track;
        end
        // strict less-than keeps the lowest index on equal distances
        o_take = i_valid && !i_served && ({1'b0, o_gap} < i_best);
    end

endmodule

`default_nettype wire

### rtl/sstf_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sstf_div import sstf_pkg::*; #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quot,
    output t_div_stat             o_stat
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [NUM_W-1:0]  r_num,  n_num;
    logic [DEN_W-1:0]  r_rem,  n_rem;
    logic [DEN_W-1:0]  r_den,  n_den;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = diff[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_iter = r_iter - ITER_W'(1);
            if (r_iter == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_iter = ITER_W'(NUM_W);
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_quot      = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

### rtl/sstf_disk_seek_cost.sv
// Shortest-seek-first batch cost. Requests (track, sector cost, last) are taken one per
// cycle into a track memory while o_in_stall is low; the request flagged last closes the
// batch, and requests beyond MAX_REQUESTS are dropped and reported through o_overflow.
// The batch is then served from the configured head position: each pass scans all N kept
// entries through the memory read port and one shared distance/compare unit, over N
// passes, after which a restoring divider forms floor((seek distance + sector cost) / N).
// Input stays stalled from the closing transfer until the result transfer. head_start may
// be written only while no batch is being served.
`default_nettype none

module sstf_disk_seek_cost import sstf_pkg::*; #(
    parameter int MAX_REQUESTS = 1024,
    parameter int TRACK_BITS   = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [TRACK_BITS-1:0] i_cfg_wr_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [TRACK_BITS-1:0] i_track,
    input  wire logic [SECTOR_W-1:0]   i_sector_cost,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [((TRACK_BITS > SECTOR_W) ? TRACK_BITS : SECTOR_W):0] o_average_cost,
    output logic [$clog2(MAX_REQUESTS + 1)-1:0] o_request_count,
    output logic                       o_overflow
);

    localparam int ADDR_W  = $clog2(MAX_REQUESTS);
    localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);
    localparam int DIST_W  = TRACK_BITS + CNT_W;
    localparam int SEC_W   = SECTOR_W + CNT_W;
    localparam int SUM_W   = ((SEC_W > DIST_W) ? SEC_W : DIST_W) + 1;
    localparam int AVG_W   = ((TRACK_BITS > SECTOR_W) ? TRACK_BITS : SECTOR_W) + 1;
    localparam int ENTRY_W = TRACK_BITS + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_PASS_END,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [TRACK_BITS-1:0] r_head_start, n_head_start;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SEC_W-1:0]    r_sec, n_sec;
    logic                r_dropped, n_dropped;
    logic                r_data_vld, n_data_vld;
    logic                r_div_go, n_div_go;

    logic [CNT_W-1:0]    r_issue, n_issue;
    logic [ADDR_W-1:0]   r_data_idx, n_data_idx;
    logic [CNT_W-1:0]    r_done, n_done;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [TRACK_BITS-1:0] r_head, n_head;
    logic [TRACK_BITS:0] r_best, n_best;
    logic [ADDR_W-1:0]   r_pick, n_pick;
    logic [TRACK_BITS-1:0] r_pick_trk, n_pick_trk;
    logic [AVG_W-1:0]    r_avg, n_avg;

    // entry = {served, track}; every entry below the count is rewritten at load
    logic [ENTRY_W-1:0]  r_mem [MAX_REQUESTS];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    logic                in_xfer;
    logic                out_xfer;
    logic                full;
    logic [TRACK_BITS-1:0] gap;
    logic                take;
    logic [SUM_W-1:0]    quot;
    t_div_stat           div_stat;

    localparam logic [TRACK_BITS:0] BEST_INF = {1'b1, {TRACK_BITS{1'b0}}};

    sstf_gap_cmp #(
        .TRACK_BITS (TRACK_BITS)
    ) u_cmp (
        .i_valid  (r_data_vld),
        .i_served (r_rd_data[TRACK_BITS]),
        .i_track  (r_rd_data[TRACK_BITS-1:0]),
        .i_head   (r_head),
        .i_best   (r_best),
        .o_gap    (gap),
        .o_take   (take)
    );

    sstf_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (SUM_W'(r_dist) + SUM_W'(r_sec)),
        .i_den   (r_count),
        .o_quot  (quot),
        .o_stat  (div_stat)
    );

    assign o_in_stall      = (r_state != S_LOAD);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_average_cost  = r_avg;
    assign o_request_count = r_count;
    assign o_overflow      = r_dropped;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;
    assign full     = (r_count == CNT_W'(MAX_REQUESTS));
    assign rd_addr  = r_issue[ADDR_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[ADDR_W-1:0];
        wr_data = {1'b0, i_track};
        if (r_state == S_LOAD) begin
            wr_en = in_xfer && !full;
        end else if (r_state == S_PASS_END) begin
            wr_en   = 1'b1;
            wr_addr = r_pick;
            wr_data = {1'b1, r_pick_trk};
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head_start = i_cfg_wr_en ? i_cfg_wr_data : r_head_start;
        n_count      = r_count;
        n_sec        = r_sec;
        n_dropped    = r_dropped;
        n_data_vld   = 1'b0;
        n_div_go     = 1'b0;
        n_issue      = r_issue;
        n_data_idx   = rd_addr;
        n_done       = r_done;
        n_dist       = r_dist;
        n_head       = r_head;
        n_best       = r_best;
        n_pick       = r_pick;
        n_pick_trk   = r_pick_trk;
        n_avg        = r_avg;

        if (take) begin
            n_best     = {1'b0, gap};
            n_pick     = r_data_idx;
            n_pick_trk = r_rd_data[TRACK_BITS-1:0];
        end

        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        n_sec   = r_sec + SEC_W'(i_sector_cost);
                    end
                    if (i_last) begin
                        n_state = S_SCAN;
                        n_head  = r_head_start;
                        n_dist  = '0;
                        n_best  = BEST_INF;
                        n_issue = '0;
                        n_done  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_issue != r_count) begin
                    n_issue    = r_issue + CNT_W'(1);
                    n_data_vld = 1'b1;
                end else if (!r_data_vld) begin
                    n_state = S_PASS_END;
                end
            end
            S_PASS_END: begin
                n_dist  = r_dist + DIST_W'(r_best[TRACK_BITS-1:0]);
                n_head  = r_pick_trk;
                n_best  = BEST_INF;
                n_issue = '0;
                n_done  = r_done + CNT_W'(1);
                if ((r_done + CNT_W'(1)) == r_count) begin
                    n_state  = S_DIV;
                    n_div_go = 1'b1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_avg   = quot[AVG_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_state   = S_LOAD;
                    n_count   = '0;
                    n_sec     = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_head_start <= TRACK_BITS'(HEAD_START_RESET);
            r_count      <= '0;
            r_sec        <= '0;
            r_dropped    <= 1'b0;
            r_data_vld   <= 1'b0;
            r_div_go     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_start <= n_head_start;
            r_count      <= n_count;
            r_sec        <= n_sec;
            r_dropped    <= n_dropped;
            r_data_vld   <= n_data_vld;
            r_div_go     <= n_div_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_data_idx <= n_data_idx;
        r_done     <= n_done;
        r_dist     <= n_dist;
        r_head     <= n_head;
        r_best     <= n_best;
        r_pick     <= n_pick;
        r_pick_trk <= n_pick_trk;
        r_avg      <= n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/sstf_chk.sv
`default_nettype none

`include "sstf_disk_seek_cost_macros.svh"

module sstf_chk import sstf_pkg::*; #(
    parameter int MAX_REQUESTS = 1024,
    parameter int TRACK_BITS   = 13
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic i_last,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic [((TRACK_BITS > SECTOR_W) ? TRACK_BITS : SECTOR_W):0] o_average_cost,
    input wire logic [$clog2(MAX_REQUESTS + 1)-1:0] o_request_count,
    input wire logic o_overflow
);

    // no new request is taken while a result is pending
    `SSTF_ASSERT_MSG(a_stall_while_result, o_out_valid |-> o_in_stall, "input open with result pending")

    `SSTF_ASSERT_MSG(a_result_holds, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_average_cost) && $stable(o_request_count) && $stable(o_overflow), "stalled result changed")

    `SSTF_ASSERT_MSG(a_count_nonzero, o_out_valid |-> (o_request_count != '0), "empty batch reported")

    // after the result transfer the next batch can start at once
    `SSTF_ASSERT_MSG(a_reopen_after_result, o_out_valid && !i_out_stall |=> !o_in_stall && !o_out_valid, "input not reopened")

    `SSTF_ASSERT_MSG(a_open_after_mid_item, i_in_valid && !o_in_stall && !i_last |=> !o_in_stall && !o_out_valid, "stalled inside a batch")

endmodule

bind sstf_disk_seek_cost sstf_chk #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
) u_chk (.*);

`default_nettype wire
